/* hw/rtl/postfix_expression_evaluator_unit_macros.svh */
// Assertion macros shared by the postfix evaluator RTL.
// No dependencies; included by files that carry assertions.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pfx_eval_pkg.sv */
// Types and character constants of the postfix evaluator.
// No dependencies; used by the decoder and the top level.
`timescale 1ns / 1ps

package pfx_eval_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_STAR = 8'h2A;

  localparam logic [31:0] TEN = 32'd10;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_SEP   = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_ADD   = 2'd2,
    KIND_MUL   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } dec_t;

endpackage

/* hw/rtl/pfx_eval_in_if.sv */
// Input channel of the postfix evaluator: one character word per handshake.
// No dependencies.
`timescale 1ns / 1ps

interface pfx_eval_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

/* hw/rtl/pfx_eval_out_if.sv */
// Result channel of the postfix evaluator: value and status word.
// No dependencies.
`timescale 1ns / 1ps

interface pfx_eval_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

/* hw/rtl/pfx_eval_decode.sv */
// Character classifier: digit, add, multiply or separator.
// Depends on pfx_eval_pkg.
`timescale 1ns / 1ps

module pfx_eval_decode (
  input  logic [7:0]         ch_i,
  output pfx_eval_pkg::dec_t dec_o
);
  import pfx_eval_pkg::*;

  logic [7:0] offset;

  assign offset = ch_i - CH_ZERO;

  always_comb begin
    dec_o.digit = offset[3:0];
    if (ch_i >= CH_ZERO && ch_i <= CH_NINE) begin
      dec_o.kind = KIND_DIGIT;
    end else if (ch_i == CH_PLUS) begin
      dec_o.kind = KIND_ADD;
    end else if (ch_i == CH_STAR) begin
      dec_o.kind = KIND_MUL;
    end else begin
      dec_o.kind = KIND_SEP;
    end
  end
endmodule

/* hw/rtl/pfx_eval_stack_ram.sv */
// Operand stack storage below the two cached top entries.
// One write and one registered read per cycle, with write-to-read forwarding.
`timescale 1ns / 1ps

module pfx_eval_stack_ram #(
  parameter int unsigned Depth = 62,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);
  logic [31:0] mem [Depth];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A word written to the address being read is forwarded into the registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_addr_i == rd_addr_i) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
endmodule

/* hw/rtl/postfix_expression_evaluator_unit.sv */
// Postfix expression evaluator: one character word per cycle, back to back.
// A result word is registered as its last character leaves the input register.
// Throughput: one character per cycle, set by the registered update of the two
// cached top entries and the one-write/one-read stack RAM; a waiting result holds
// back only the last character of the next expression.
// Reset clears the input, state and result control; the stack RAM needs no clearing.
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_unit_macros.svh"

module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pfx_eval_in_if.sink    in_i,
  pfx_eval_out_if.source out_o
);
  import pfx_eval_pkg::*;

  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MemDepth = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  localparam logic [CntW-1:0] CntFull  = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntZero  = CntW'(0);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);
  localparam logic [CntW-1:0] CntTwo   = CntW'(2);
  localparam logic [CntW-1:0] CntThree = CntW'(3);

  // Input register.
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;

  // Stack state; the top two entries live in registers.
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_num_q, in_num_d;
  status_e         err_q, err_d;
  logic [31:0]     top_q, top_d;
  logic [31:0]     nxt_q, nxt_d;

  // Result register.
  logic        res_valid_q;
  logic [31:0] res_value_q, res_value_d;
  status_e     res_status_q, res_status_d;

  logic            advance;
  logic            proc;
  dec_t            dec;
  logic [31:0]     sum;
  logic [31:0]     prod;
  logic [31:0]     acc;
  logic [31:0]     digit_ext;
  logic            wr_en;
  logic [CntW-1:0] wr_full;
  logic [CntW-1:0] rd_full;
  logic [31:0]     third;

  // Only a character that ends an expression needs the result register to be free.
  assign advance    = !res_valid_q || out_o.ready;
  assign proc       = in_valid_q && (advance || !last_q);
  assign in_i.ready = !in_valid_q || proc;

  pfx_eval_decode u_decode (
    .ch_i  (ch_q),
    .dec_o (dec)
  );

  assign digit_ext = {28'd0, dec.digit};
  assign sum       = top_q + nxt_q;
  assign prod      = top_q * nxt_q;
  assign acc       = top_q * TEN + digit_ext;

  assign wr_full = cnt_q - CntTwo;
  assign rd_full = cnt_d - CntThree;

  pfx_eval_stack_ram #(
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_full[AddrW-1:0]),
    .wr_data_i (nxt_q),
    .rd_addr_i (rd_full[AddrW-1:0]),
    .rd_data_o (third)
  );

  always_comb begin
    cnt_d        = cnt_q;
    in_num_d     = in_num_q;
    err_d        = err_q;
    top_d        = top_q;
    nxt_d        = nxt_q;
    wr_en        = 1'b0;
    res_value_d  = 32'd0;
    res_status_d = ST_OK;
    if (proc) begin
      case (dec.kind)
        KIND_DIGIT: begin
          if (in_num_q && cnt_q != CntZero) begin
            top_d = acc;
          end else begin
            in_num_d = 1'b0;
            if (cnt_q >= CntFull) begin
              if (err_q == ST_OK) begin
                err_d = ST_OVER;
              end
            end else begin
              // The second entry spills into the RAM when a third one lands.
              top_d    = digit_ext;
              nxt_d    = top_q;
              cnt_d    = cnt_q + CntOne;
              in_num_d = 1'b1;
              wr_en    = (cnt_q >= CntTwo);
            end
          end
        end
        KIND_ADD, KIND_MUL: begin
          in_num_d = 1'b0;
          if (cnt_q < CntTwo) begin
            if (err_q == ST_OK) begin
              err_d = ST_UNDER;
            end
          end else begin
            top_d = (dec.kind == KIND_ADD) ? sum : prod;
            nxt_d = third;
            cnt_d = cnt_q - CntOne;
          end
        end
        default: begin
          in_num_d = 1'b0;
        end
      endcase
      if (last_q) begin
        if (cnt_d != CntZero) begin
          res_value_d  = top_d;
          res_status_d = err_d;
        end else begin
          res_status_d = (err_d == ST_OK) ? ST_UNDER : err_d;
        end
        cnt_d    = CntZero;
        in_num_d = 1'b0;
        err_d    = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= CntZero;
      in_num_q <= 1'b0;
      err_q    <= ST_OK;
    end else begin
      cnt_q    <= cnt_d;
      in_num_q <= in_num_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    nxt_q <= nxt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= proc && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_o.valid  = res_valid_q;
  assign out_o.value  = $signed(res_value_q);
  assign out_o.status = res_status_q;

  `PFX_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, proc && last_q,
                   cnt_q == CntZero && !in_num_q && err_q == ST_OK,
                   "stack state not cleared after the end of an expression")
  `PFX_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, proc && !last_q && err_q != ST_OK,
                   err_q == $past(err_q), "recorded error changed within an expression")
  `PFX_ASSERT_NEXT(a_op_pops_one, clk_i, rst_ni,
                   proc && !last_q && cnt_q >= CntTwo &&
                   (dec.kind == KIND_ADD || dec.kind == KIND_MUL),
                   cnt_q == $past(cnt_q) - CntOne, "operator did not pop exactly one entry")
  `PFX_ASSERT_NOW(a_count_bound, clk_i, rst_ni, in_valid_q || res_valid_q || !in_valid_q,
                  cnt_q <= CntFull, "stack count above the stack depth")

endmodule
